FILE: rtl/core/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, off while reset is high
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Condition that must hold in the cycle after reset
`define ASSERT_RST(lbl, clk, rst, cons) \
  lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("post-reset check failed");

`endif

FILE: rtl/core/cid_pkg.sv
// ============================================================================
// CID encoder package
// Types, constants and the base32 alphabet shared by the encoder modules.
// ============================================================================
package cid_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_CONTENT_CODEC = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGEST_LENGTH = 1'd1;

  localparam logic [31:0] CODEC_RESET = 32'd85;
  localparam logic [5:0]  DLEN_RESET  = 6'd32;

  // Header bytes and characters
  localparam logic [7:0] VERSION_BYTE   = 8'h01;
  localparam logic [7:0] MULTIHASH_CODE = 8'h12;
  localparam logic [6:0] PREFIX_CHAR    = 7'h62;
  localparam logic [6:0] CHAR_A         = 7'h61;
  localparam logic [6:0] CHAR_TWO       = 7'h32;

  // Header sequencer phase
  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_VERSION,
    PH_CODEC,
    PH_MHASH,
    PH_LENGTH,
    PH_DIGEST
  } hdr_phase_t;

  // Byte token offered from the sequencer to the packer
  typedef struct packed {
    logic       valid;
    logic       prefix;
    logic [7:0] data;
    logic       last;
  } tok_t;

  // Map a 5-bit group to its lowercase base32 character
  function automatic logic [6:0] sym_char(input logic [4:0] s);
    logic [6:0] c;
    if (s < 5'd26) begin
      c = CHAR_A + {2'b00, s};
    end else begin
      c = CHAR_TWO + {2'b00, s - 5'd26};
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/cid_byte_if.sv
// ============================================================================
// Digest byte channel
// Valid/ready channel carrying one digest byte per transaction.
// ============================================================================
interface cid_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] digest_byte;

  modport source (output valid, output digest_byte, input ready);
  modport sink (input valid, input digest_byte, output ready);
endinterface

FILE: rtl/core/cid_char_if.sv
// ============================================================================
// Identifier character channel
// Valid/ready channel carrying one ASCII character per transaction.
// ============================================================================
interface cid_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] symbol_char;
  logic       is_last;

  modport source (output valid, output symbol_char, output is_last, input ready);
  modport sink (input valid, input symbol_char, input is_last, output ready);
endinterface

FILE: rtl/core/cid_hdr_seq.sv
// ============================================================================
// CID header sequencer
// Holds the configuration and one digest byte, and offers the byte stream
// (prefix, version, codec varint, multihash code, length, digest) to the packer.
// ============================================================================
module cid_hdr_seq (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [cid_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cid_pkg::CFG_DATA_W-1:0]    cfg_data,
  cid_byte_if.sink                          digest,
  output cid_pkg::tok_t                     tok,
  input  logic                              tok_take
);
  import cid_pkg::*;

  logic [31:0] codec;
  logic [5:0]  dlen;
  logic        slot_valid;
  logic [7:0]  d_byte;
  logic        d_last;
  logic [5:0]  bytes_taken;
  hdr_phase_t  phase, phase_next;
  logic [2:0]  vidx, vidx_next;
  logic [2:0]  vlast;
  logic [6:0]  grp;
  logic        accept;
  logic        first;
  logic        last_calc;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      codec <= CODEC_RESET;
      dlen  <= DLEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CONTENT_CODEC: codec <= cfg_data;
        CFG_DIGEST_LENGTH: dlen  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Accept a new byte when the slot is empty or its digest token leaves now
  assign digest.ready = !slot_valid || (tok_take && (phase == PH_DIGEST));
  assign accept       = digest.valid && digest.ready;
  assign first        = (bytes_taken == 6'd0);
  assign last_calc    = ({1'b0, bytes_taken} + 7'd1) >= {1'b0, dlen};

  // Hold the byte slot and the per-identifier byte count
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid  <= 1'b0;
      bytes_taken <= 6'd0;
    end else if (accept) begin
      slot_valid  <= 1'b1;
      bytes_taken <= last_calc ? 6'd0 : bytes_taken + 6'd1;
    end else if (tok_take && (phase == PH_DIGEST)) begin
      slot_valid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      d_byte <= digest.digest_byte;
      d_last <= last_calc;
    end
  end

  // Varint length: index of the highest nonzero 7-bit group
  always_comb begin
    if (|codec[31:28]) begin
      vlast = 3'd4;
    end else if (|codec[27:21]) begin
      vlast = 3'd3;
    end else if (|codec[20:14]) begin
      vlast = 3'd2;
    end else if (|codec[13:7]) begin
      vlast = 3'd1;
    end else begin
      vlast = 3'd0;
    end
  end

  always_comb begin
    case (vidx)
      3'd0:    grp = codec[6:0];
      3'd1:    grp = codec[13:7];
      3'd2:    grp = codec[20:14];
      3'd3:    grp = codec[27:21];
      3'd4:    grp = {3'b000, codec[31:28]};
      default: grp = 7'd0;
    endcase
  end

  // Phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_DIGEST;
      vidx  <= 3'd0;
    end else begin
      phase <= phase_next;
      vidx  <= vidx_next;
    end
  end

  // Advance through the header and select the offered byte
  always_comb begin
    phase_next = phase;
    vidx_next  = vidx;
    tok.valid  = slot_valid;
    tok.prefix = 1'b0;
    tok.data   = 8'h00;
    tok.last   = 1'b0;
    unique case (phase)
      PH_PREFIX: begin
        tok.prefix = 1'b1;
        if (tok_take) phase_next = PH_VERSION;
      end
      PH_VERSION: begin
        tok.data = VERSION_BYTE;
        if (tok_take) begin
          phase_next = PH_CODEC;
          vidx_next  = 3'd0;
        end
      end
      PH_CODEC: begin
        tok.data = {(vidx != vlast), grp};
        if (tok_take) begin
          if (vidx == vlast) begin
            phase_next = PH_MHASH;
          end else begin
            vidx_next = vidx + 3'd1;
          end
        end
      end
      PH_MHASH: begin
        tok.data = MULTIHASH_CODE;
        if (tok_take) phase_next = PH_LENGTH;
      end
      PH_LENGTH: begin
        tok.data = {2'b00, dlen};
        if (tok_take) phase_next = PH_DIGEST;
      end
      PH_DIGEST: begin
        tok.data = d_byte;
        tok.last = d_last;
      end
      default: phase_next = PH_DIGEST;
    endcase
    if (accept) begin
      phase_next = first ? PH_PREFIX : PH_DIGEST;
    end
  end

endmodule

FILE: rtl/core/cid_b32_pack.sv
// ============================================================================
// CID base32 packer
// Shifts bytes into a 12-bit buffer and emits one base32 character per cycle
// into a free output register, with the zero-padded flush at identifier end.
// ============================================================================
module cid_b32_pack (
  input  logic          clk,
  input  logic          rst,
  input  cid_pkg::tok_t tok,
  output logic          tok_take,
  cid_char_if.source    symbol
);
  import cid_pkg::*;

  logic [11:0] bit_buffer, bit_buffer_next;
  logic [3:0]  bits_held, bits_held_next;
  logic        last_pend, last_pend_next;
  logic        o_valid;
  logic [6:0]  o_char;
  logic        o_last;
  logic        load;
  logic        emit;
  logic [6:0]  char_next;
  logic        last_next;
  logic [11:0] new_buffer;
  logic [3:0]  new_held;
  logic [3:0]  held_sh;
  logic [3:0]  new_sh;
  logic [4:0]  held_sym;
  logic [4:0]  new_sym;
  logic [4:0]  flush_sym;

  assign load = !o_valid || symbol.ready;

  // Pick the next character: buffered group, flush, prefix, or a fresh byte
  always_comb begin
    new_buffer      = {bit_buffer[3:0], tok.data};
    new_held        = bits_held + 4'd8;
    held_sh         = bits_held - 4'd5;
    new_sh          = new_held - 4'd5;
    held_sym        = 5'(bit_buffer >> held_sh);
    new_sym         = 5'(new_buffer >> new_sh);
    flush_sym       = 5'(bit_buffer[4:0] << (3'd5 - bits_held[2:0]));
    emit            = 1'b0;
    char_next       = 7'd0;
    last_next       = 1'b0;
    bit_buffer_next = bit_buffer;
    bits_held_next  = bits_held;
    last_pend_next  = last_pend;
    tok_take        = 1'b0;
    if (load) begin
      if (bits_held >= 4'd5) begin
        emit           = 1'b1;
        char_next      = sym_char(held_sym);
        bits_held_next = held_sh;
        last_next      = last_pend && (held_sh == 4'd0);
        if (last_next) last_pend_next = 1'b0;
      end else if (last_pend) begin
        emit           = 1'b1;
        char_next      = sym_char(flush_sym);
        last_next      = 1'b1;
        bits_held_next = 4'd0;
        last_pend_next = 1'b0;
      end else if (tok.valid) begin
        tok_take = 1'b1;
        emit     = 1'b1;
        if (tok.prefix) begin
          char_next = PREFIX_CHAR;
        end else begin
          char_next       = sym_char(new_sym);
          bit_buffer_next = new_buffer;
          bits_held_next  = new_sh;
          last_pend_next  = tok.last;
        end
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      bits_held <= 4'd0;
      last_pend <= 1'b0;
      o_valid   <= 1'b0;
    end else begin
      bits_held <= bits_held_next;
      last_pend <= last_pend_next;
      if (load) o_valid <= emit;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    bit_buffer <= bit_buffer_next;
    if (load && emit) begin
      o_char <= char_next;
      o_last <= last_next;
    end
  end

  assign symbol.valid       = o_valid;
  assign symbol.symbol_char = o_char;
  assign symbol.is_last     = o_last;

endmodule

FILE: rtl/core/cid_v1_base32_encoder.sv
// ============================================================================
// CID v1 base32 encoder
// Turns a stream of hash digest bytes into version-1 content identifier text.
// ============================================================================
// Usage:
//   digest carries one digest byte per transaction; symbol carries one ASCII
//   character per transaction, is_last marking the final one of an identifier.
//   cfg_we/cfg_index/cfg_data write content_codec (index 0) and
//   digest_length (index 1); write them only while the block is idle.
// Path: an accepted byte waits in the byte slot, and its characters are
//   registered in the output register when the packer is free.
// Throughput: one character per cycle while symbol.ready is high, set by the
//   single packer that emits one 5-bit group or the prefix per cycle. A digest
//   byte gives 1 or 2 characters; the first byte of an identifier adds the
//   prefix and header, and the last byte adds at most one flush character.
// Reset: rst (synchronous) clears the byte count, the held-bit count and both
//   valids, and restores content_codec to 85 and digest_length to 32.
// Stall: while symbol.ready is low the output register holds its character;
//   the byte slot still takes at most one new byte, then digest.ready drops.
// ============================================================================
module cid_v1_base32_encoder (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [cid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cid_pkg::CFG_DATA_W-1:0] cfg_data,
  cid_byte_if.sink                       digest,
  cid_char_if.source                     symbol
);
  import cid_pkg::*;

  tok_t tok;
  logic tok_take;

  // Header sequencer and byte slot
  cid_hdr_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .digest    (digest),
    .tok       (tok),
    .tok_take  (tok_take)
  );

  // Base32 packer and output register
  cid_b32_pack u_pack (
    .clk      (clk),
    .rst      (rst),
    .tok      (tok),
    .tok_take (tok_take),
    .symbol   (symbol)
  );

endmodule

FILE: rtl/core/cid_checker.sv
// ============================================================================
// CID encoder port checker
// Watches top-level channels: output stability, legal characters, reset idle.
// ============================================================================
`include "assert_macros.svh"

module cid_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] symbol_char,
  input logic       is_last
);

  logic out_stall;
  logic char_ok;

  assign out_stall = out_valid && !out_ready;
  assign char_ok   = (symbol_char >= 7'h61 && symbol_char <= 7'h7a) ||
                     (symbol_char >= 7'h32 && symbol_char <= 7'h37);

  // Output stays offered while stalled
  `ASSERT_NXT(a_out_hold, clk, rst, out_stall, out_valid)

  // Stalled character and last mark do not change
  `ASSERT_NXT(a_out_stable, clk, rst, out_stall, $stable(symbol_char) && $stable(is_last))

  // Every character is the prefix letter or from the base32 alphabet
  `ASSERT_IMP(a_char_legal, clk, rst, out_valid, char_ok)

  // Nothing offered and the byte slot open right after reset
  `ASSERT_RST(a_reset_idle, clk, rst, !out_valid && in_ready)

endmodule

bind cid_v1_base32_encoder cid_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (digest.ready),
  .out_valid   (symbol.valid),
  .out_ready   (symbol.ready),
  .symbol_char (symbol.symbol_char),
  .is_last     (symbol.is_last)
);

FILE: tb/cid_v1_base32_encoder_tb.sv
// ============================================================================
// CID v1 base32 encoder testbench
// Streams digest bytes into the encoder and checks every identifier character
// against a cycle-free predictor of the prefix, header, digest and flush.
// Runs directed cases, then random traffic under several idle/stall mixes,
// and a long output hold-off that backs up the input.
// ============================================================================
module cid_v1_base32_encoder_tb;
  import cid_pkg::*;

  typedef struct packed {
    logic [6:0] code;
    logic       is_last;
  } char_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cid_byte_if digest_ch ();
  cid_char_if symbol_ch ();

  cid_v1_base32_encoder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .digest    (digest_ch),
    .symbol    (symbol_ch)
  );

  // Predictor copy of the registers and the encoder state
  logic [31:0] codec_reg;
  logic [5:0]  length_reg;
  logic [11:0] acc_bits;
  logic [3:0]  acc_count;
  logic [5:0]  digest_count;

  char_t expected_chars[$];
  int    mismatch_count = 0;
  int    tx_idle_pct = 0;
  int    rx_stall_pct = 0;
  logic  rx_hold = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Map a 5-bit group to its lowercase alphabet character
  function automatic logic [6:0] base32_char(input logic [4:0] s);
    logic [6:0] c;
    if (s < 5'd26) begin
      c = 7'h61 + {2'b00, s};
    end else begin
      c = 7'h32 + {2'b00, s - 5'd26};
    end
    return c;
  endfunction

  function automatic void queue_char(input logic [6:0] c);
    char_t item;
    item.code    = c;
    item.is_last = 1'b0;
    expected_chars.push_back(item);
  endfunction

  // Append one byte to the bit accumulator and emit every full group
  function automatic void shift_into_buffer(input logic [7:0] b);
    logic [11:0] grp;
    acc_bits  = {acc_bits[3:0], b};
    acc_count = acc_count + 4'd8;
    while (acc_count >= 4'd5) begin
      grp = acc_bits >> (acc_count - 4'd5);
      queue_char(base32_char(grp[4:0]));
      acc_count = acc_count - 4'd5;
      acc_bits  = acc_bits & ((12'd1 << acc_count) - 12'd1);
    end
  endfunction

  // Predict all characters caused by one accepted digest byte
  function automatic void encode_digest_byte(input logic [7:0] b);
    logic [31:0] v;
    logic [11:0] grp;
    char_t       tail;
    if (digest_count == 6'd0) begin
      acc_bits  = '0;
      acc_count = '0;
      queue_char(PREFIX_CHAR);
      shift_into_buffer(VERSION_BYTE);
      v = codec_reg;
      while (v >= 32'h80) begin
        shift_into_buffer({1'b1, v[6:0]});
        v = v >> 7;
      end
      shift_into_buffer(v[7:0]);
      shift_into_buffer(MULTIHASH_CODE);
      shift_into_buffer({2'b00, length_reg});
    end
    shift_into_buffer(b);
    if ({1'b0, digest_count} + 7'd1 >= {1'b0, length_reg}) begin
      // flush the zero-padded remainder and mark the end
      if (acc_count != 4'd0) begin
        grp = acc_bits << (4'd5 - acc_count);
        queue_char(base32_char(grp[4:0]));
      end
      tail = expected_chars.pop_back();
      tail.is_last = 1'b1;
      expected_chars.push_back(tail);
      acc_bits     = '0;
      acc_count    = '0;
      digest_count = '0;
    end else begin
      digest_count = digest_count + 6'd1;
    end
  endfunction

  function automatic void check_symbol(input logic [6:0] c, input logic last);
    char_t want;
    if (expected_chars.size() == 0) begin
      $display("%0t: unexpected character expected none actual %h is_last %b",
               $time, c, last);
      mismatch_count++;
    end else begin
      want = expected_chars.pop_front();
      if (c !== want.code) begin
        $display("%0t: symbol_char mismatch expected %h actual %h", $time, want.code, c);
        mismatch_count++;
      end
      if (last !== want.is_last) begin
        $display("%0t: is_last mismatch expected %b actual %b", $time, want.is_last, last);
        mismatch_count++;
      end
    end
  endfunction

  // Check each output transaction, then pick ready for the next cycle
  always @(posedge clk) begin
    if (!rst && symbol_ch.valid && symbol_ch.ready) begin
      check_symbol(symbol_ch.symbol_char, symbol_ch.is_last);
    end
    if (rx_hold) begin
      symbol_ch.ready <= 1'b0;
    end else begin
      symbol_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Offer one byte after a random gap and hold it until accepted
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      digest_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    digest_ch.valid       <= 1'b1;
    digest_ch.digest_byte <= b;
    do @(posedge clk); while (!digest_ch.ready);
    encode_digest_byte(b);
  endtask

  // Drop valid and wait until every predicted character has come out
  task automatic wait_idle();
    digest_ch.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    if (idx == CFG_CONTENT_CODEC) begin
      codec_reg = value;
    end else begin
      length_reg = value[5:0];
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Write digest_length with random upper bits, which the block drops
  task automatic write_length(input logic [5:0] len);
    logic [31:0] word;
    word = $urandom;
    word[5:0] = len;
    write_reg(CFG_DIGEST_LENGTH, word);
  endtask

  // Reset values, then a register write that ends the identifier early
  task automatic test_reset_defaults();
    send_byte(8'h00);
    send_byte(8'hFF);
    wait_idle();
    write_length(6'd1);
    send_byte(8'hA5);
    wait_idle();
  endtask

  // Codec varints of one, two, three and five bytes, single-byte digests
  task automatic test_codec_varint_widths();
    logic [31:0] codecs[6];
    logic [7:0]  bytes[6];
    codecs = '{32'h0, 32'h7F, 32'h80, 32'h3FFF, 32'h4000, 32'hFFFF_FFFF};
    bytes  = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01, 8'h80};
    write_length(6'd1);
    for (int i = 0; i < 6; i++) begin
      write_reg(CFG_CONTENT_CODEC, codecs[i]);
      send_byte(bytes[i]);
      wait_idle();
    end
  endtask

  // A zero length acts as one byte but is still sent as zero
  task automatic test_zero_length();
    write_reg(CFG_CONTENT_CODEC, 32'd85);
    write_length(6'd0);
    send_byte(8'hFF);
    send_byte(8'h00);
    wait_idle();
  endtask

  task automatic test_short_digests();
    write_length(6'd3);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h7E);
    wait_idle();
    write_length(6'd2);
    send_byte(8'hC3);
    send_byte(8'h3C);
    wait_idle();
  endtask

  // Whole identifiers with random codec, length and content
  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_bytes);
    int          sent;
    int          pick;
    int          width;
    logic [31:0] codec;
    logic [5:0]  len;
    tx_idle_pct = tx_pct;
    rx_stall_pct <= rx_pct;
    sent = 0;
    while (sent < n_bytes) begin
      wait_idle();
      // spread the codec over every varint width
      width = 7 * ($urandom_range(4) + 1);
      codec = $urandom;
      if (width < 32) codec = codec & ((32'd1 << width) - 32'd1);
      write_reg(CFG_CONTENT_CODEC, codec);
      pick = $urandom_range(99);
      if (pick < 70) begin
        len = 6'($urandom_range(6, 1));
      end else if (pick < 80) begin
        len = 6'd0;
      end else if (pick < 95) begin
        len = 6'($urandom_range(20, 7));
      end else begin
        len = 6'($urandom_range(63, 40));
      end
      write_length(len);
      do begin
        send_byte(8'($urandom));
        sent++;
        // occasionally change the length inside an identifier
        if (digest_count != 6'd0 && $urandom_range(11) == 0) begin
          wait_idle();
          write_length(6'($urandom_range(8)));
        end
      end while (digest_count != 6'd0);
    end
    wait_idle();
  endtask

  // Hold the output off for a long stretch while bytes keep coming
  task automatic test_output_backpressure();
    tx_idle_pct = 0;
    rx_stall_pct <= 0;
    write_reg(CFG_CONTENT_CODEC, $urandom);
    write_length(6'd8);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (160) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    for (int i = 0; i < 24; i++) begin
      send_byte(8'($urandom));
    end
    wait_idle();
  endtask

  initial begin
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    digest_ch.valid       = 1'b0;
    digest_ch.digest_byte = '0;
    codec_reg             = CODEC_RESET;
    length_reg            = DLEN_RESET;
    acc_bits              = '0;
    acc_count             = '0;
    digest_count          = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_codec_varint_widths();
    test_zero_length();
    test_short_digests();
    test_random_traffic(0, 0, 12);
    test_random_traffic(65, 0, 12);
    test_random_traffic(0, 65, 12);
    test_random_traffic(19, 19, 12);
    test_output_backpressure();

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("cid_v1_base32_encoder_tb: clean");
    end else begin
      $display("cid_v1_base32_encoder_tb: errors");
    end
    $finish;
  end

  // End a hung run
  initial begin
    #(12 * 500000);
    $display("cid_v1_base32_encoder_tb: errors");
    $finish;
  end

endmodule
